>>> rtl/core/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types and constants of the image download sequencer.
// ----------------------------------------------------------------------------
package ids_pkg;

	localparam int DEF_WORDS_PER_PACKET = 125;
	localparam int DEF_MAX_IMAGE_BYTES  = 81920;

	localparam int OFF_W       = 17;	// byte offset into the image store
	localparam int END_W       = 18;	// end of a packet, may reach 2^17
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		ST_PROGRESS = 3'd0,
		ST_ACCEPTED = 3'd1,
		ST_REJECTED = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_COMPLETE = 3'd4
	} status_t;

	// One classified word, front to back.
	typedef struct packed {
		logic [7:0]       slave;
		logic [15:0]      value;
		logic [7:0]       pos;
		logic             first;	// word 0 of a request
		logic             last;
		logic             cnt_ok;	// word count matches the packet length
		logic             pos_ok;	// position inside the packet
		logic             len_ok;	// position of the final word
		logic             range_ok;	// packet index within the image limit
		logic [OFF_W-1:0] offset;	// byte offset of this word
		logic [END_W-1:0] pkt_end;	// byte count covered up to this packet
	} entry_t;

	typedef struct packed {
		logic             write_enable;
		logic [OFF_W-1:0] write_offset;
		logic [15:0]      write_data;
		logic             packet_done;
		status_t          status;
		logic             start_upgrade;
	} result_t;

endpackage

>>> rtl/core/image_download_sequencer.sv
// ----------------------------------------------------------------------------
// image_download_sequencer
// Firmware download sequencer: checks request words and emits image writes.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | one request word: slave, word_count, word_value, tlast
//  m_*      | out | one result per word: write, status, start_upgrade
//
//  One beat per cycle while the queue has room; an accepted beat is registered
//  into a queue entry and then into the result register, and is presented from there.
//  The 4-entry queue lets the front keep taking words while the result
//  register is stalled; s_tready drops only when the queue is full.
//  Reset (arst_n low) clears the position counter, the queue and all
//  download state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module image_download_sequencer #(
	parameter int WORDS_PER_PACKET = ids_pkg::DEF_WORDS_PER_PACKET,
	parameter int MAX_IMAGE_BYTES  = ids_pkg::DEF_MAX_IMAGE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,	// slave[7:0], word_count[15:8], word_value[31:16]
	input  logic        s_tlast,	// last_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,	// write_offset[16:0], write_data[32:17],
					// status[35:33], start_upgrade[36], zero[39:37]
	output logic        m_tuser,	// write_enable
	output logic        m_tlast		// packet_done
);
	import ids_pkg::*;

	logic    accept;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	entry_t  f_entry;
	entry_t  q_head;
	result_t res;

	// Take a beat whenever the queue has room.
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	ids_front #(
		.WORDS_PER_PACKET(WORDS_PER_PACKET),
		.MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.slave     (s_tdata[7:0]),
		.word_count(s_tdata[15:8]),
		.word_value(s_tdata[31:16]),
		.last_word (s_tlast),
		.entry     (f_entry)
	);

	ids_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_entry(f_entry),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// Execute in order; hold the result until the consumer takes it.
	ids_back #(
		.MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (q_head),
		.pop      (q_pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tdata = {3'd0, res.start_upgrade, res.status, res.write_data, res.write_offset};
	assign m_tuser = res.write_enable;
	assign m_tlast = res.packet_done;

endmodule

>>> rtl/core/ids_front.sv
// ----------------------------------------------------------------------------
// ids_front
// Tracks the word position within a request and classifies each beat.
// ----------------------------------------------------------------------------
module ids_front #(
	parameter int WORDS_PER_PACKET = ids_pkg::DEF_WORDS_PER_PACKET,
	parameter int MAX_IMAGE_BYTES  = ids_pkg::DEF_MAX_IMAGE_BYTES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      slave,
	input  logic [7:0]      word_count,
	input  logic [15:0]     word_value,
	input  logic            last_word,
	output ids_pkg::entry_t entry
);
	import ids_pkg::*;

	localparam int PACK_BYTES     = 2 * (WORDS_PER_PACKET - 1);
	localparam int TOP_PACKET_IDX = MAX_IMAGE_BYTES / PACK_BYTES;
	localparam logic [7:0] WPP    = 8'(WORDS_PER_PACKET);
	localparam logic [7:0] LAST_POS = 8'(WORDS_PER_PACKET - 1);
	localparam logic [8:0] PACK_C = 9'(PACK_BYTES);

	logic [7:0]       pos_q;
	logic [OFF_W-1:0] off_q;
	logic [END_W-1:0] end_q;
	logic [24:0]      prod;

	assign prod = {9'd0, word_value} * {16'd0, PACK_C};

	always_comb begin
		entry.slave    = slave;
		entry.value    = word_value;
		entry.pos      = pos_q;
		entry.first    = (pos_q == 8'd0);
		entry.last     = last_word;
		entry.cnt_ok   = (word_count == WPP);
		entry.pos_ok   = (pos_q < WPP);
		entry.len_ok   = (pos_q == LAST_POS);
		entry.range_ok = ({1'b0, word_value} <= 17'(TOP_PACKET_IDX));
		entry.offset   = off_q;
		entry.pkt_end  = end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (last_word) begin
				pos_q <= '0;
			end else if (pos_q != 8'hFF) begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

	// Base offsets of the packet; only meaningful once the packet is valid.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q == 8'd0) begin
				end_q <= prod[END_W-1:0];
				off_q <= OFF_W'(prod[END_W-1:0] - END_W'(PACK_BYTES));
			end else begin
				off_q <= off_q + OFF_W'(2);
			end
		end
	end

endmodule

>>> rtl/core/ids_queue.sv
// ----------------------------------------------------------------------------
// ids_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module ids_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ids_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output ids_pkg::entry_t head
);
	import ids_pkg::*;

	entry_t            mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/ids_back.sv
// ----------------------------------------------------------------------------
// ids_back
// Holds the download state, executes each word and registers its result.
// ----------------------------------------------------------------------------
module ids_back #(
	parameter int MAX_IMAGE_BYTES = ids_pkg::DEF_MAX_IMAGE_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  ids_pkg::entry_t  head,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_ready,
	output ids_pkg::result_t res
);
	import ids_pkg::*;

	logic        valid_q;
	result_t     res_q;
	logic [15:0] last_index_q;
	logic        locked_q;
	logic [7:0]  owner_q;
	logic [31:0] size_q;
	logic [31:0] exp_q;
	logic [31:0] sum_q;
	logic        ok_q;
	logic [15:0] pidx_q;

	logic [15:0] last_index_d;
	logic        locked_d;
	logic [7:0]  owner_d;
	logic [31:0] size_d;
	logic [31:0] exp_d;
	logic [31:0] sum_d;
	logic        ok_d;
	logic [15:0] pidx_d;
	result_t     res_d;
	logic [31:0] off_w;
	logic [31:0] b_hi;
	logic [31:0] b_lo;

	assign pop       = !empty && (!valid_q || res_ready);
	assign res_valid = valid_q;
	assign res       = res_q;

	assign off_w = {15'd0, head.offset};
	assign b_hi  = (off_w < size_q) ? {24'd0, head.value[15:8]} : 32'd0;
	assign b_lo  = ((off_w + 32'd1) < size_q) ? {24'd0, head.value[7:0]} : 32'd0;

	always_comb begin
		last_index_d = last_index_q;
		locked_d     = locked_q;
		owner_d      = owner_q;
		size_d       = size_q;
		exp_d        = exp_q;
		sum_d        = sum_q;
		ok_d         = ok_q;
		pidx_d       = pidx_q;
		res_d        = '0;
		res_d.packet_done = head.last;
		res_d.status      = ST_PROGRESS;

		if (head.first) begin
			pidx_d = head.value;
			if (!head.cnt_ok) begin
				ok_d = 1'b0;
			end else if (head.value == 16'd0) begin
				ok_d         = 1'b1;
				owner_d      = head.slave;
				last_index_d = '0;
				locked_d     = 1'b0;
				sum_d        = '0;
			end else begin
				ok_d = !locked_q && head.range_ok && (head.slave == owner_q)
					&& ({1'b0, head.value} == ({1'b0, last_index_q} + 17'd1));
			end
		end else begin
			if (!head.cnt_ok || !head.pos_ok) begin
				ok_d = 1'b0;
			end
			if (ok_d) begin
				if (pidx_q == 16'd0) begin
					case (head.pos)
						8'd1: size_d[31:16] = head.value;
						8'd2: size_d[15:0]  = head.value;
						8'd3: exp_d[31:16]  = head.value;
						8'd4: exp_d[15:0]   = head.value;
						default: ;
					endcase
				end else begin
					res_d.write_enable = 1'b1;
					res_d.write_offset = head.offset;
					res_d.write_data   = head.value;
					sum_d = sum_q + b_hi + b_lo;
				end
			end
		end

		if (head.last) begin
			if (!ok_d || !head.len_ok) begin
				res_d.status = ST_REJECTED;
			end else if (pidx_d == 16'd0) begin
				res_d.status = (size_q > 32'(MAX_IMAGE_BYTES)) ? ST_REJECTED : ST_ACCEPTED;
			end else begin
				last_index_d = pidx_d;
				if ({14'd0, head.pkt_end} >= size_q) begin
					if (sum_d == exp_q) begin
						locked_d            = 1'b1;
						res_d.start_upgrade = 1'b1;
						res_d.status        = ST_COMPLETE;
					end else begin
						res_d.status = ST_MISMATCH;
					end
				end else begin
					res_d.status = ST_ACCEPTED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			last_index_q <= '0;
			locked_q     <= 1'b0;
			owner_q      <= '0;
			size_q       <= '0;
			exp_q        <= '0;
			sum_q        <= '0;
			ok_q         <= 1'b0;
			pidx_q       <= '0;
		end else begin
			if (pop) begin
				valid_q      <= 1'b1;
				last_index_q <= last_index_d;
				locked_q     <= locked_d;
				owner_q      <= owner_d;
				size_q       <= size_d;
				exp_q        <= exp_d;
				sum_q        <= sum_d;
				ok_q         <= ok_d;
				pidx_q       <= pidx_d;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule
